// ===== hdl/device_address_binding_table_macros.svh =====
// Assertion macros shared by the checker of the device address binding table.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef DEVICE_ADDRESS_BINDING_TABLE_MACROS_SVH
`define DEVICE_ADDRESS_BINDING_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DABT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DABT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dabt_pkg.sv =====
// Package of the device address binding table: opcodes, states, entry record,
// controller command and status structs, and address compare helpers. No dependencies.
`timescale 1ns / 1ps

package dabt_pkg;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_UPDATE    = 4'd1,
    OP_BIND      = 4'd2,
    OP_REMOVE    = 4'd3,
    OP_GET_DEV   = 4'd4,
    OP_GET_ADDR  = 4'd5,
    OP_GET_INDEX = 4'd6,
    OP_COUNT     = 4'd7,
    OP_CLEAR     = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ACT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [21:0] dev;
    logic [15:0] apdu;
    logic [55:0] mac;
    logic [2:0]  mac_len;
    logic [15:0] net;
    logic [55:0] rem;
    logic [2:0]  rem_len;
  } entry_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic act;
  } cmd_t;

  typedef struct packed {
    logic last_issue;
  } status_t;

  // Byte enables for the low bytes within the length, capped at the compared width.
  function automatic logic [55:0] byte_mask(input logic [2:0] len, input int unsigned nbytes);
    logic [55:0] m;
    m = '0;
    for (int j = 0; j < 7; j++) begin
      if ((j < int'(len)) && (j < nbytes)) begin
        m[j*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // Address equality; the remote part only counts off the local network.
  function automatic logic addr_match(input entry_t e, input entry_t q,
                                      input int unsigned nbytes);
    logic [55:0] mm;
    logic [55:0] rm;
    logic        ok;
    mm = byte_mask(q.mac_len, nbytes);
    rm = byte_mask(q.rem_len, nbytes);
    ok = (e.mac_len == q.mac_len) && ((e.mac & mm) == (q.mac & mm)) && (e.net == q.net);
    if (q.net != 16'd0) begin
      ok = ok && (e.rem_len == q.rem_len) && ((e.rem & rm) == (q.rem & rm));
    end
    return ok;
  endfunction

endpackage

// ===== hdl/dabt_ctrl.sv =====
// Controller of the device address binding table: sequences accept, table scan,
// update and result hand-off. Depends on dabt_pkg.
`timescale 1ns / 1ps

module dabt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  dabt_pkg::status_t status,
  output dabt_pkg::cmd_t    cmd
);

  dabt_pkg::state_t state;
  dabt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dabt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      dabt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = dabt_pkg::ST_SCAN;
        end
      end
      dabt_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.last_issue) begin
          state_next = dabt_pkg::ST_DRAIN;
        end
      end
      dabt_pkg::ST_DRAIN: begin
        state_next = dabt_pkg::ST_ACT;
      end
      dabt_pkg::ST_ACT: begin
        cmd.act    = 1'b1;
        state_next = dabt_pkg::ST_OUT;
      end
      dabt_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = dabt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dabt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/dabt_dpath.sv =====
// Datapath of the device address binding table: entry memory, in-use and pending
// flags, scan compare, update and result registers. Depends on dabt_pkg.
`timescale 1ns / 1ps

module dabt_dpath #(
  parameter int ENTRIES    = 16,
  parameter int ADDR_BYTES = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  dabt_pkg::cmd_t     cmd,
  output dabt_pkg::status_t  status,
  input  logic [3:0]         opcode,
  input  logic [21:0]        device_number,
  input  logic [15:0]        apdu_limit,
  input  logic [55:0]        mac_bytes,
  input  logic [2:0]         mac_length,
  input  logic [15:0]        network_number,
  input  logic [55:0]        remote_bytes,
  input  logic [2:0]         remote_length,
  input  logic [7:0]         slot_index,
  output logic               found,
  output dabt_pkg::entry_t   found_entry,
  output logic [4:0]         bound_count
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  dabt_pkg::entry_t mem [ENTRIES];
  dabt_pkg::entry_t rdata;
  dabt_pkg::entry_t req;
  dabt_pkg::entry_t hit_data;
  dabt_pkg::entry_t wdata;

  logic [ENTRIES-1:0] in_use;
  logic [ENTRIES-1:0] pend;
  logic [3:0]         op;
  logic [7:0]         slot;
  logic [IW-1:0]      cnt;
  logic [IW-1:0]      pidx;
  logic               pvld;
  logic               hit_found;
  logic [IW-1:0]      hit_idx;
  logic               hit_pend;
  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic [CW-1:0]      bound;
  logic               hit_now;
  logic               we;
  logic [IW-1:0]      waddr;
  logic               report;

  assign status.last_issue = cmd.issue && (cnt == LAST);

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.issue) begin
      rdata <= mem[cnt];
    end
  end

  // Per-entry hit condition, selected by the operation.
  always_comb begin
    hit_now = 1'b0;
    case (op)
      dabt_pkg::OP_ADD, dabt_pkg::OP_UPDATE, dabt_pkg::OP_BIND,
      dabt_pkg::OP_REMOVE, dabt_pkg::OP_GET_DEV: begin
        hit_now = in_use[pidx] && (rdata.dev == req.dev);
      end
      dabt_pkg::OP_GET_ADDR: begin
        hit_now = in_use[pidx] && !pend[pidx]
                  && dabt_pkg::addr_match(rdata, req, ADDR_BYTES);
      end
      dabt_pkg::OP_GET_INDEX: begin
        hit_now = in_use[pidx] && ({1'b0, slot} == 9'(pidx));
      end
      default: begin
        hit_now = 1'b0;
      end
    endcase
  end

  // Update of the table after the scan.
  always_comb begin
    we     = 1'b0;
    waddr  = hit_idx;
    wdata  = req;
    report = 1'b0;
    case (op)
      dabt_pkg::OP_ADD, dabt_pkg::OP_UPDATE: begin
        if (hit_found) begin
          we = cmd.act;
        end else if (free_found && (op == dabt_pkg::OP_ADD)) begin
          we    = cmd.act;
          waddr = free_idx;
        end
      end
      dabt_pkg::OP_BIND: begin
        if (hit_found) begin
          report = !hit_pend;
        end else if (free_found) begin
          we        = cmd.act;
          waddr     = free_idx;
          wdata     = '0;
          wdata.dev = req.dev;
        end
      end
      dabt_pkg::OP_GET_DEV: begin
        report = hit_found && !hit_pend;
      end
      dabt_pkg::OP_GET_ADDR, dabt_pkg::OP_GET_INDEX: begin
        report = hit_found;
      end
      default: begin
        report = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      pend   <= '0;
      pvld   <= 1'b0;
    end else begin
      pvld <= cmd.issue;
      if (cmd.act) begin
        if (we) begin
          in_use[waddr] <= 1'b1;
          pend[waddr]   <= (op == dabt_pkg::OP_BIND);
        end
        if ((op == dabt_pkg::OP_REMOVE) && hit_found) begin
          in_use[hit_idx] <= 1'b0;
          pend[hit_idx]   <= 1'b0;
        end
        if (op == dabt_pkg::OP_CLEAR) begin
          in_use <= '0;
          pend   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op           <= opcode;
      slot         <= slot_index;
      req.dev      <= device_number;
      req.apdu     <= apdu_limit;
      req.mac      <= mac_bytes;
      req.mac_len  <= mac_length;
      req.net      <= network_number;
      req.rem      <= remote_bytes;
      req.rem_len  <= remote_length;
      cnt          <= '0;
      hit_found    <= 1'b0;
      free_found   <= 1'b0;
      bound        <= '0;
    end else begin
      if (cmd.issue) begin
        cnt  <= cnt + 1'b1;
        pidx <= cnt;
      end
      if (pvld) begin
        if (hit_now && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= pidx;
          hit_pend  <= pend[pidx];
          hit_data  <= rdata;
        end
        if (!in_use[pidx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= pidx;
        end
        if (in_use[pidx] && !pend[pidx]) begin
          bound <= bound + 1'b1;
        end
      end
    end
    if (cmd.act) begin
      found       <= report;
      found_entry <= report ? hit_data : '0;
      if (op == dabt_pkg::OP_COUNT) begin
        bound_count <= (32'(bound) > 32'd31) ? 5'd31 : 5'(bound);
      end else begin
        bound_count <= 5'd0;
      end
    end
  end

endmodule

// ===== hdl/device_address_binding_table.sv =====
// Device address binding table. After an item is accepted, the table is scanned
// one entry per cycle through the single memory read port; then the read pipeline
// drains, the table is updated and the result is offered. A new item is taken only
// after the result has been taken, so any output stall also holds the input.
// Reset (rst, synchronous, active high) frees every entry and returns to idle;
// entry contents are not cleared and are only used for entries in use.
`timescale 1ns / 1ps

module device_address_binding_table #(
  parameter int ENTRIES    = 16,
  parameter int ADDR_BYTES = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  opcode,
  input  logic [21:0] device_number,
  input  logic [15:0] apdu_limit,
  input  logic [55:0] mac_bytes,
  input  logic [2:0]  mac_length,
  input  logic [15:0] network_number,
  input  logic [55:0] remote_bytes,
  input  logic [2:0]  remote_length,
  input  logic [7:0]  slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [21:0] found_device,
  output logic [15:0] found_apdu_limit,
  output logic [55:0] found_mac,
  output logic [2:0]  found_mac_length,
  output logic [15:0] found_network,
  output logic [55:0] found_remote,
  output logic [2:0]  found_remote_length,
  output logic [4:0]  bound_count
);

  // The controller walks accept, scan, drain of the read pipeline, update and
  // result hand-off. The datapath holds the table and all item state.
  dabt_pkg::cmd_t    cmd;
  dabt_pkg::status_t status;
  dabt_pkg::entry_t  found_entry;

  dabt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // During the scan each entry is compared once: the first hit in index order
  // and the first free entry are recorded, and bound entries are counted.
  dabt_dpath #(
    .ENTRIES    (ENTRIES),
    .ADDR_BYTES (ADDR_BYTES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .opcode         (opcode),
    .device_number  (device_number),
    .apdu_limit     (apdu_limit),
    .mac_bytes      (mac_bytes),
    .mac_length     (mac_length),
    .network_number (network_number),
    .remote_bytes   (remote_bytes),
    .remote_length  (remote_length),
    .slot_index     (slot_index),
    .found          (found),
    .found_entry    (found_entry),
    .bound_count    (bound_count)
  );

  // The result registers hold still while the result waits to be taken.
  assign found_device        = found_entry.dev;
  assign found_apdu_limit    = found_entry.apdu;
  assign found_mac           = found_entry.mac;
  assign found_mac_length    = found_entry.mac_len;
  assign found_network       = found_entry.net;
  assign found_remote        = found_entry.rem;
  assign found_remote_length = found_entry.rem_len;

endmodule

// ===== hdl/dabt_checker.sv =====
// Port-level checker for the device address binding table, bound to the top level.
// Depends on device_address_binding_table_macros.svh.
`timescale 1ns / 1ps
`include "device_address_binding_table_macros.svh"

module dabt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        found,
  input logic [21:0] found_device,
  input logic [55:0] found_mac,
  input logic [4:0]  bound_count
);

  `DABT_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "item accepted while busy")
  `DABT_ASSERT_SAME(a_no_accept_with_result, clk, rst, out_valid, in_stall, "input taken while result pending")
  `DABT_ASSERT_SAME(a_miss_is_zero, clk, rst, out_valid && !found, (found_device == 22'd0) && (found_mac == 56'd0), "miss with nonzero fields")
  `DABT_ASSERT_SAME(a_count_not_found, clk, rst, out_valid && (bound_count != 5'd0), !found, "count result marked found")
  `DABT_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && out_stall, out_valid && $stable(found_device), "stalled result changed")

endmodule

bind device_address_binding_table dabt_checker u_dabt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .found        (found),
  .found_device (found_device),
  .found_mac    (found_mac),
  .bound_count  (bound_count)
);
